>>> design/ntmp_pkg.sv
// shared constants and key scale table for the note text to midi pitch unit
package ntmp_pkg;

  localparam int unsigned KeyW        = 4;
  localparam int unsigned NumKeys     = 14;
  localparam int unsigned NumLetters  = 7;
  localparam int unsigned StoreDepth  = 14;
  localparam int unsigned IdxW        = 4;
  localparam int unsigned AccW        = 9;
  localparam int unsigned OctW        = 6;

  localparam logic [7:0]      NoteBase    = 8'h3c;
  localparam logic [AccW-1:0] NaturalMark = 9'h0ff;

  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChFlat  = 8'h5f;
  localparam logic [7:0] ChSharp = 8'h5e;
  localparam logic [7:0] ChNat   = 8'h3d;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpG   = 8'h47;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoG   = 8'h67;
  localparam logic [7:0] ChLoZ   = 8'h7a;

  localparam logic [KeyW-1:0] KeyDefault = 4'd0;

  // semitones above c for letters a..g, one row per major key
  localparam logic [7:0] KeySteps [NumKeys][NumLetters] = '{
    '{8'd9,  8'd11, 8'd0,   8'd2, 8'd4, 8'd5, 8'd7},
    '{8'd9,  8'd11, 8'd0,   8'd2, 8'd4, 8'd6, 8'd7},
    '{8'd9,  8'd11, 8'd1,   8'd2, 8'd4, 8'd6, 8'd7},
    '{8'd9,  8'd11, 8'd1,   8'd2, 8'd4, 8'd6, 8'd8},
    '{8'd9,  8'd11, 8'd1,   8'd3, 8'd4, 8'd6, 8'd8},
    '{8'd10, 8'd11, 8'd1,   8'd3, 8'd4, 8'd6, 8'd8},
    '{8'd10, 8'd11, 8'd1,   8'd3, 8'd5, 8'd6, 8'd8},
    '{8'd8,  8'd10, 8'd255, 8'd1, 8'd3, 8'd5, 8'd6},
    '{8'd10, 8'd12, 8'd1,   8'd3, 8'd5, 8'd6, 8'd8},
    '{8'd8,  8'd10, 8'd0,   8'd1, 8'd3, 8'd5, 8'd6},
    '{8'd8,  8'd10, 8'd0,   8'd1, 8'd3, 8'd5, 8'd7},
    '{8'd8,  8'd10, 8'd0,   8'd2, 8'd3, 8'd5, 8'd7},
    '{8'd9,  8'd10, 8'd0,   8'd2, 8'd3, 8'd5, 8'd7},
    '{8'd9,  8'd10, 8'd0,   8'd2, 8'd4, 8'd5, 8'd7}
  };

  // scale step of a store index in a key, upper octave for lower-case letters
  function automatic logic [7:0] step_of(logic [KeyW-1:0] key, logic [IdxW-1:0] idx);
    logic [KeyW-1:0] k;
    logic [2:0]      letter;
    logic [7:0]      up;
    k = (key > KeyW'(NumKeys - 1)) ? KeyDefault : key;
    if (idx >= IdxW'(NumLetters)) begin
      letter = 3'(idx - IdxW'(NumLetters));
      up     = 8'd12;
    end else begin
      letter = idx[2:0];
      up     = 8'd0;
    end
    return KeySteps[k][letter] + up;
  endfunction

endpackage

>>> design/note_text_to_midi_pitch_unit.sv
// top level: abc note token characters in, midi pitch out
// Takes one character or bar event per cycle and answers one pitch per note token, in the
// cycle after the token's last character is accepted. An input request is taken every cycle
// unless a finished pitch is held in the output register while the output side stalls. The
// path from the input character through the store read and the pitch sum into the output
// register is combinational. The accidental store is 14 flip-flop entries, cleared at reset and in
// the cycle a bar event is accepted, so no clearing pass is needed.
module note_text_to_midi_pitch_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ntmp_pkg::KeyW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     opcode_i,
  input  logic [7:0]               char_code_i,
  input  logic                     last_char_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               midi_pitch_o,
  output logic                     letter_found_o
);

  logic [ntmp_pkg::KeyW-1:0] key_q;
  logic [ntmp_pkg::AccW-1:0] store_q [ntmp_pkg::StoreDepth];
  logic [ntmp_pkg::AccW-1:0] acc_q, acc_d;
  logic [ntmp_pkg::OctW-1:0] oct_q, oct_d;
  logic [ntmp_pkg::IdxW-1:0] idx_q, idx_d;
  logic                      alpha_q, alpha_d;
  logic                      lv_q, lv_d;
  logic                      out_valid_q;
  logic [7:0]                pitch_q, pitch_d;
  logic                      found_q;

  logic                      in_acc;
  logic                      is_upper, is_lower;
  logic [7:0]                plain, keyed, step_sum, oct12;
  logic [7:0]                oct_ext;
  logic [ntmp_pkg::AccW-1:0] st;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // token state update for one character
  always_comb begin
    oct_d   = oct_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    alpha_d = alpha_q;
    lv_d    = lv_q;
    if (char_code_i == ntmp_pkg::ChComma) begin
      oct_d = oct_q - 6'd1;
    end else if (char_code_i == ntmp_pkg::ChApos) begin
      oct_d = oct_q + 6'd1;
    end
    is_upper = char_code_i inside {[ntmp_pkg::ChUpA:ntmp_pkg::ChUpZ]};
    is_lower = char_code_i inside {[ntmp_pkg::ChLoA:ntmp_pkg::ChLoZ]};
    if (!alpha_q) begin
      if (is_upper || is_lower) begin
        alpha_d = 1'b1;
        if (is_upper && char_code_i <= ntmp_pkg::ChUpG) begin
          lv_d  = 1'b1;
          idx_d = 4'(char_code_i - ntmp_pkg::ChUpA);
        end else if (is_lower && char_code_i <= ntmp_pkg::ChLoG) begin
          lv_d  = 1'b1;
          idx_d = 4'(char_code_i - ntmp_pkg::ChLoA + 8'(ntmp_pkg::NumLetters));
        end
      end else if (char_code_i == ntmp_pkg::ChFlat) begin
        acc_d = acc_q - 9'd1;
      end else if (char_code_i == ntmp_pkg::ChSharp) begin
        acc_d = acc_q + 9'd1;
      end else if (char_code_i == ntmp_pkg::ChNat) begin
        acc_d = ntmp_pkg::NaturalMark;
      end
    end
  end

  // pitch of the token if this character ends it
  always_comb begin
    plain = ntmp_pkg::step_of(ntmp_pkg::KeyDefault, idx_d);
    keyed = ntmp_pkg::step_of(key_q, idx_d);
    st    = store_q[idx_d];
    if (acc_d == ntmp_pkg::NaturalMark) begin
      step_sum = plain;
    end else if (acc_d != '0) begin
      step_sum = plain + acc_d[7:0];
    end else if (st == ntmp_pkg::NaturalMark) begin
      step_sum = plain;
    end else if (st == '0) begin
      step_sum = keyed;
    end else begin
      step_sum = plain + st[7:0];
    end
    oct_ext = {2'b00, oct_d};
    oct12   = (oct_ext << 3) + (oct_ext << 2);
    pitch_d = lv_d ? (step_sum + oct12 + ntmp_pkg::NoteBase) : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= ntmp_pkg::KeyDefault;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      oct_q   <= '0;
      idx_q   <= '0;
      alpha_q <= 1'b0;
      lv_q    <= 1'b0;
      for (int i = 0; i < ntmp_pkg::StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else if (in_acc) begin
      if (opcode_i) begin
        for (int i = 0; i < ntmp_pkg::StoreDepth; i++) begin
          store_q[i] <= '0;
        end
      end else if (last_char_i) begin
        if (lv_d && acc_d != '0) begin
          store_q[idx_d] <= acc_d;
        end
        acc_q   <= '0;
        oct_q   <= '0;
        idx_q   <= '0;
        alpha_q <= 1'b0;
        lv_q    <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        oct_q   <= oct_d;
        idx_q   <= idx_d;
        alpha_q <= alpha_d;
        lv_q    <= lv_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && !opcode_i && last_char_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !opcode_i && last_char_i) begin
      pitch_q <= pitch_d;
      found_q <= lv_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign midi_pitch_o   = pitch_q;
  assign letter_found_o = found_q;

  // a token that ends produces a pitch in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !opcode_i && last_char_i) |=> out_valid_q)
    else $error("token end did not produce a pitch");

  // no note letter means pitch zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (pitch_q == 8'd0))
    else $error("pitch nonzero without a note letter");

  // a note letter is only valid after a letter was seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lv_q |-> alpha_q)
    else $error("letter valid without letter seen");

  // a bar request empties the accidental store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i) |=> (store_q[0] == '0 && store_q[ntmp_pkg::StoreDepth-1] == '0))
    else $error("store not cleared by bar");

  // a held pitch stays put while the output side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(pitch_q) && $stable(found_q)))
    else $error("stalled pitch changed");

endmodule

>>> bench/testbench.sv
// self-checking testbench for the note text to midi pitch unit
module testbench;

  localparam logic OpChar = 1'b0;
  localparam logic OpBar  = 1'b1;

  localparam logic [ntmp_pkg::KeyW-1:0] KeyCMajor = 4'd0;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned MaxShown   = 40;
  localparam int unsigned PhaseItems = 330;
  localparam int unsigned NumPhases  = 6;

  typedef struct {
    logic       op;
    logic [7:0] ch;
    logic       last;
  } request_t;

  typedef struct {
    logic [7:0] pitch;
    logic       found;
  } pitch_t;

  // semitones above c for letters a..g, rows in key register order
  localparam logic [7:0] ScaleSteps [14][7] = '{
    '{8'd9,  8'd11, 8'd0,   8'd2, 8'd4, 8'd5, 8'd7},
    '{8'd9,  8'd11, 8'd0,   8'd2, 8'd4, 8'd6, 8'd7},
    '{8'd9,  8'd11, 8'd1,   8'd2, 8'd4, 8'd6, 8'd7},
    '{8'd9,  8'd11, 8'd1,   8'd2, 8'd4, 8'd6, 8'd8},
    '{8'd9,  8'd11, 8'd1,   8'd3, 8'd4, 8'd6, 8'd8},
    '{8'd10, 8'd11, 8'd1,   8'd3, 8'd4, 8'd6, 8'd8},
    '{8'd10, 8'd11, 8'd1,   8'd3, 8'd5, 8'd6, 8'd8},
    '{8'd8,  8'd10, 8'd255, 8'd1, 8'd3, 8'd5, 8'd6},
    '{8'd10, 8'd12, 8'd1,   8'd3, 8'd5, 8'd6, 8'd8},
    '{8'd8,  8'd10, 8'd0,   8'd1, 8'd3, 8'd5, 8'd6},
    '{8'd8,  8'd10, 8'd0,   8'd1, 8'd3, 8'd5, 8'd7},
    '{8'd8,  8'd10, 8'd0,   8'd2, 8'd3, 8'd5, 8'd7},
    '{8'd9,  8'd10, 8'd0,   8'd2, 8'd3, 8'd5, 8'd7},
    '{8'd9,  8'd10, 8'd0,   8'd2, 8'd4, 8'd5, 8'd7}
  };

  class pitch_scoreboard;
    logic [ntmp_pkg::KeyW-1:0] key;
    logic [ntmp_pkg::AccW-1:0] accid_mem [ntmp_pkg::StoreDepth];
    logic [ntmp_pkg::AccW-1:0] accid;
    logic [ntmp_pkg::OctW-1:0] octave;
    logic [ntmp_pkg::IdxW-1:0] letter;
    logic                      alpha_seen;
    logic                      letter_ok;
    pitch_t                    pitch_q [$];
    int unsigned               errors;

    function new();
      key = KeyCMajor;
      foreach (accid_mem[i]) accid_mem[i] = '0;
      clear_token();
      errors = 0;
    endfunction

    function void clear_token();
      accid      = '0;
      octave     = '0;
      letter     = '0;
      alpha_seen = 1'b0;
      letter_ok  = 1'b0;
    endfunction

    function logic [7:0] key_step(logic [ntmp_pkg::KeyW-1:0] k,
                                  logic [ntmp_pkg::IdxW-1:0] idx);
      int unsigned row;
      int unsigned col;
      row = (k >= ntmp_pkg::NumKeys) ? 0 : k;
      col = idx % ntmp_pkg::NumLetters;
      return ScaleSteps[row][col] + ((idx >= ntmp_pkg::NumLetters) ? 8'd12 : 8'd0);
    endfunction

    function int unsigned pending();
      return pitch_q.size();
    endfunction

    function void note_request(logic op, logic [7:0] ch, logic last);
      logic [7:0]                plain;
      logic [7:0]                p;
      logic [7:0]                oct_w;
      logic [ntmp_pkg::AccW-1:0] held;
      pitch_t                    res;
      if (op == OpBar) begin
        foreach (accid_mem[i]) accid_mem[i] = '0;
        return;
      end
      if (ch == ntmp_pkg::ChComma) octave = octave - 1'b1;
      else if (ch == ntmp_pkg::ChApos) octave = octave + 1'b1;
      if (!alpha_seen) begin
        if ((ch >= ntmp_pkg::ChUpA && ch <= ntmp_pkg::ChUpZ) ||
            (ch >= ntmp_pkg::ChLoA && ch <= ntmp_pkg::ChLoZ)) begin
          alpha_seen = 1'b1;
          if (ch >= ntmp_pkg::ChUpA && ch <= ntmp_pkg::ChUpG) begin
            letter_ok = 1'b1;
            letter    = 4'(ch - ntmp_pkg::ChUpA);
          end else if (ch >= ntmp_pkg::ChLoA && ch <= ntmp_pkg::ChLoG) begin
            letter_ok = 1'b1;
            letter    = 4'(ch - ntmp_pkg::ChLoA) + 4'd7;
          end
        end else if (ch == ntmp_pkg::ChFlat) begin
          accid = accid - 1'b1;
        end else if (ch == ntmp_pkg::ChSharp) begin
          accid = accid + 1'b1;
        end else if (ch == ntmp_pkg::ChNat) begin
          accid = ntmp_pkg::NaturalMark;
        end
      end
      if (!last) return;
      res.found = letter_ok;
      res.pitch = 8'd0;
      if (letter_ok) begin
        plain = key_step(KeyCMajor, letter);
        if (accid != '0) accid_mem[letter] = accid;
        // an explicit accidental wins, else whatever the measure holds
        held = (accid != '0) ? accid : accid_mem[letter];
        if (held == ntmp_pkg::NaturalMark) p = plain;
        else if (held == '0) p = key_step(key, letter);
        else p = plain + held[7:0];
        oct_w = 8'(octave);
        p = p + oct_w * 8'd12;
        res.pitch = p + ntmp_pkg::NoteBase;
      end
      pitch_q.push_back(res);
      clear_token();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MaxShown) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic [7:0] pitch, logic found);
      pitch_t want;
      if (pitch_q.size() == 0) begin
        report_mismatch($sformatf("pitch %0d with no token pending", pitch));
        return;
      end
      want = pitch_q.pop_front();
      if (pitch !== want.pitch)
        report_mismatch($sformatf("midi_pitch %0d, want %0d", pitch, want.pitch));
      if (found !== want.found)
        report_mismatch($sformatf("letter_found %0b, want %0b", found, want.found));
    endtask
  endclass

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      cfg_we_i       = 1'b0;
  logic [ntmp_pkg::KeyW-1:0] cfg_wdata_i    = '0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic                      opcode_i       = 1'b0;
  logic [7:0]                char_code_i    = 8'd0;
  logic                      last_char_i    = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic [7:0]                midi_pitch_o;
  logic                      letter_found_o;

  pitch_scoreboard sb;
  int unsigned     send_idle_pct  = 28;
  int unsigned     recv_stall_pct = 70;
  int unsigned     items_sent     = 0;
  logic            hold_req       = 1'b0;

  note_text_to_midi_pitch_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .midi_pitch_o   (midi_pitch_o),
    .letter_found_o (letter_found_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(midi_pitch_o, letter_found_o);
  end

  // output side: random stalls, or one long hold-off when asked
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic request_t chr(logic [7:0] c, logic last);
    request_t rq;
    rq.op   = OpChar;
    rq.ch   = c;
    rq.last = last;
    return rq;
  endfunction

  function automatic request_t bar_request();
    request_t rq;
    rq.op   = OpBar;
    rq.ch   = 8'($urandom_range(255));
    rq.last = 1'($urandom_range(1));
    return rq;
  endfunction

  function automatic logic [7:0] pick_accidental();
    case ($urandom_range(2))
      0:       return ntmp_pkg::ChFlat;
      1:       return ntmp_pkg::ChSharp;
      default: return ntmp_pkg::ChNat;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? ntmp_pkg::ChUpA : ntmp_pkg::ChLoA;
    if ($urandom_range(99) < 85) return base + 8'($urandom_range(6));
    return base + 8'($urandom_range(25, 7));
  endfunction

  task automatic send_request(request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= rq.op;
    char_code_i <= rq.ch;
    last_char_i <= rq.last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(rq.op, rq.ch, rq.last);
    items_sent++;
  endtask

  // marks the final character and sends the whole token
  task automatic send_token(request_t tok [$]);
    tok[tok.size() - 1].last = 1'b1;
    foreach (tok[i]) send_request(tok[i]);
  endtask

  task automatic send_text(string s);
    request_t tok [$];
    for (int i = 0; i < s.len(); i++) tok.push_back(chr(s[i], 1'b0));
    send_token(tok);
  endtask

  // long accidental and octave runs to wrap the counters
  task automatic send_long_token(logic [7:0] acc_ch, int unsigned acc_run,
                                 logic [7:0] oct_ch, int unsigned oct_run);
    request_t tok [$];
    repeat (acc_run) tok.push_back(chr(acc_ch, 1'b0));
    tok.push_back(chr(pick_letter(), 1'b0));
    repeat (oct_run) tok.push_back(chr(oct_ch, 1'b0));
    send_token(tok);
  endtask

  task automatic send_random_token();
    request_t    tok [$];
    int unsigned kind;
    int unsigned n;
    logic        sharp;
    kind = $urandom_range(999);
    if (kind < 7) begin
      sharp = 1'($urandom_range(1));
      if (sharp) n = $urandom_range(1) ? 255 : $urandom_range(300, 240);
      else n = $urandom_range(1) ? 257 : $urandom_range(300, 240);
      send_long_token(sharp ? ntmp_pkg::ChSharp : ntmp_pkg::ChFlat, n,
                      $urandom_range(1) ? ntmp_pkg::ChApos : ntmp_pkg::ChComma,
                      $urandom_range(1) ? 64 : $urandom_range(70, 1));
    end else if (kind < 80) begin
      send_request(bar_request());
    end else if (kind < 180) begin
      n = $urandom_range(4, 1);
      repeat (n) tok.push_back(chr(8'($urandom_range(255)), 1'($urandom_range(1))));
      send_token(tok);
    end else begin
      n = $urandom_range(3);
      repeat (n) tok.push_back(chr(pick_accidental(), 1'b0));
      if ($urandom_range(19) == 0) tok.push_back(chr(8'($urandom_range(255)), 1'b0));
      if ($urandom_range(24) == 0) tok.push_back(bar_request());
      tok.push_back(chr(pick_letter(), 1'b0));
      n = $urandom_range(3);
      repeat (n) begin
        case ($urandom_range(3))
          0:       tok.push_back(chr(ntmp_pkg::ChComma, 1'b0));
          1:       tok.push_back(chr(ntmp_pkg::ChApos, 1'b0));
          2:       tok.push_back(chr(pick_accidental(), 1'b0));
          default: tok.push_back(chr(8'($urandom_range(255)), 1'b0));
        endcase
      end
      send_token(tok);
    end
  endtask

  task automatic write_key(logic [ntmp_pkg::KeyW-1:0] k);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.key = k;
  endtask

  // drain all pitches, then give the pipeline time to go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    #(20 * 400_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    request_t                  tok [$];
    logic [ntmp_pkg::KeyW-1:0] phase_keys [NumPhases];
    int unsigned               target;
    sb = new();
    phase_keys = '{4'd0, 4'd13, 4'd7, 4'd15, 4'd8, 4'd0};
    phase_keys[NumPhases - 1] = 4'($urandom_range(15));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_key(4'd1);

    send_text("C");
    send_text("^F");
    send_text("F");
    send_text("=F");
    send_text("F");
    send_request(bar_request());
    send_text("F");
    send_text("_b,,");
    send_text("g''");
    send_text("z");
    send_text(",");
    tok = {chr(8'h00, 1'b1)};
    send_token(tok);
    tok = {chr(8'hff, 1'b1)};
    send_token(tok);
    // bar in the middle of a token clears the store only
    tok = {chr(ntmp_pkg::ChSharp, 1'b0), bar_request(), chr(ntmp_pkg::ChLoA + 8'd2, 1'b0)};
    send_token(tok);
    send_text("aG");

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      write_key(phase_keys[ph]);
      case (ph % 3)
        0: begin
          send_idle_pct  = 28;
          recv_stall_pct = 70;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 28;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (ph == 0) begin
        send_long_token(ntmp_pkg::ChSharp, 255, ntmp_pkg::ChApos, 64);
        send_long_token(ntmp_pkg::ChFlat, 257, ntmp_pkg::ChComma, 1);
      end
      if (ph == 2) hold_req = 1'b1;
      target = items_sent + PhaseItems;
      while (items_sent < target) send_random_token();
    end

    settle();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> note_text_to_midi_pitch_unit.f
design/ntmp_pkg.sv
design/note_text_to_midi_pitch_unit.sv
bench/testbench.sv
